// ===== design/wbrb_pkg.sv =====
`default_nettype none
package wbrb_pkg;

    localparam int VEC_W  = 32;
    localparam int ANG_W  = 34;
    localparam int FRAC_BITS = 14;
    localparam int MAX_STAGES = 24;
    localparam logic signed [ANG_W-1:0] QUARTER = 34'sh0_4000_0000;
    localparam logic signed [16:0] GAIN_Q16 = 17'sd39797;
    localparam logic signed [16:0] CDEG_TURN = 17'sd36000;
    localparam logic signed [15:0] LEN_LIMIT = 16'sd23170;
    localparam logic signed [15:0] HALF_TURN_CDEG = 16'sd18000;

    localparam logic [31:0] ATAN_TAB [MAX_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic                     valid;
        logic signed [VEC_W-1:0]  rx;
        logic signed [VEC_W-1:0]  ry;
        logic signed [ANG_W-1:0]  rz;
        logic signed [VEC_W-1:0]  vx;
        logic signed [VEC_W-1:0]  vy;
        logic signed [ANG_W-1:0]  vz;
        logic signed [15:0]       heading;
        logic                     zero;
        logic [7:0]               tag;
    } t_stage;

endpackage
`default_nettype wire

// ===== design/world_to_body_range_bearing_top.sv =====
`default_nettype none
// Converts a target point in table coordinates into the robot frame of the pose that
// arrives with the same beat, giving forward and rightward components, range and
// bearing. The pipeline takes one beat per cycle; each beat passes through the chain of
// CORDIC cells, then the gain multiply register and the rounding and saturation register.
// When the output is stalled the whole pipeline holds.
module world_to_body_range_bearing_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tag, target_x, target_y, robot_x, robot_y, robot_heading
    input  wire logic [79:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tag_out, lateral_mm, forward_mm, bearing_cdeg, range_mm
    output logic [71:0]      m_axis_tdata
);
    import wbrb_pkg::*;

    localparam int N = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES :
                       ((CORDIC_STAGES < 1) ? 1 : CORDIC_STAGES);

    t_stage w_chain [N+1];
    logic w_en;
    logic signed [14:0] w_dx, w_dy;
    logic signed [VEC_W-1:0] w_fx, w_fy;
    logic signed [ANG_W-1:0] w_z;
    logic signed [15:0] w_h;

    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_comb begin
        w_h  = $signed(s_axis_tdata[79:64]);
        w_dx = 15'($signed(s_axis_tdata[21:8])) - 15'($signed(s_axis_tdata[49:36]));
        w_dy = 15'($signed(s_axis_tdata[35:22])) - 15'($signed(s_axis_tdata[63:50]));
        w_fx = VEC_W'(w_dx) <<< FRAC_BITS;
        w_fy = VEC_W'(w_dy) <<< FRAC_BITS;
        w_z  = -({{2{w_h[15]}}, w_h, 16'h0000});
        w_chain[0].valid   = s_axis_tvalid;
        w_chain[0].tag     = s_axis_tdata[7:0];
        w_chain[0].heading = w_h;
        w_chain[0].zero    = (w_dx == '0) && (w_dy == '0);
        if (w_z > QUARTER) begin
            w_chain[0].rx = -w_fy;
            w_chain[0].ry = w_fx;
            w_chain[0].rz = w_z - QUARTER;
        end else if (w_z < -QUARTER) begin
            w_chain[0].rx = w_fy;
            w_chain[0].ry = -w_fx;
            w_chain[0].rz = w_z + QUARTER;
        end else begin
            w_chain[0].rx = w_fx;
            w_chain[0].ry = w_fy;
            w_chain[0].rz = w_z;
        end
        if (w_fx < 0) begin
            if (w_fy >= 0) begin
                w_chain[0].vx = w_fy;
                w_chain[0].vy = -w_fx;
                w_chain[0].vz = QUARTER;
            end else begin
                w_chain[0].vx = -w_fy;
                w_chain[0].vy = w_fx;
                w_chain[0].vz = -QUARTER;
            end
        end else begin
            w_chain[0].vx = w_fx;
            w_chain[0].vy = w_fy;
            w_chain[0].vz = '0;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        wbrb_cell #(.SHIFT(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    wbrb_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_stage (w_chain[N]),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata)
    );

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid) else $error("valid after reset");
    a_bearing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[55:40]) <= 16'sd18000 &&
                           $signed(m_axis_tdata[55:40]) > -16'sd18000))
        else $error("bearing out of range");
    a_range_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[70:56] <= 15'd23170 && !m_axis_tdata[71]))
        else $error("range out of limit");
    a_fwd_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[39:24]) <= 16'sd23170 &&
                           $signed(m_axis_tdata[39:24]) >= -16'sd23170))
        else $error("forward out of limit");
endmodule
`default_nettype wire

// ===== design/wbrb_cell.sv =====
`default_nettype none
module wbrb_cell #(
    parameter int SHIFT = 0
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire wbrb_pkg::t_stage i_stage,
    output wbrb_pkg::t_stage     o_stage
);
    import wbrb_pkg::*;

    localparam logic signed [ANG_W-1:0] ATAN = ANG_W'(ATAN_TAB[SHIFT]);

    t_stage r_stage;
    t_stage n_stage;
    logic signed [VEC_W-1:0] w_rxs, w_rys, w_vxs, w_vys;

    always_comb begin
        w_rxs = i_stage.rx >>> SHIFT;
        w_rys = i_stage.ry >>> SHIFT;
        w_vxs = i_stage.vx >>> SHIFT;
        w_vys = i_stage.vy >>> SHIFT;
        n_stage = i_stage;
        if (!i_stage.rz[ANG_W-1]) begin
            n_stage.rx = i_stage.rx - w_rys;
            n_stage.ry = i_stage.ry + w_rxs;
            n_stage.rz = i_stage.rz - ATAN;
        end else begin
            n_stage.rx = i_stage.rx + w_rys;
            n_stage.ry = i_stage.ry - w_rxs;
            n_stage.rz = i_stage.rz + ATAN;
        end
        if (i_stage.vy[VEC_W-1]) begin
            n_stage.vx = i_stage.vx - w_vys;
            n_stage.vy = i_stage.vy + w_vxs;
            n_stage.vz = i_stage.vz - ATAN;
        end else begin
            n_stage.vx = i_stage.vx + w_vys;
            n_stage.vy = i_stage.vy - w_vxs;
            n_stage.vz = i_stage.vz + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;
endmodule
`default_nettype wire

// ===== design/wbrb_post.sv =====
`default_nettype none
module wbrb_post (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire wbrb_pkg::t_stage i_stage,
    output logic                  o_valid,
    output logic [71:0]           o_data
);
    import wbrb_pkg::*;

    logic               r_a_valid;
    logic [7:0]         r_a_tag;
    logic signed [48:0] r_pf, r_pl, r_pr;
    logic signed [49:0] r_pb;
    logic signed [31:0] w_rel;
    logic signed [VEC_W-1:0] w_mag;
    logic signed [48:0] w_f, w_l, w_r;
    logic signed [49:0] w_b;
    logic signed [15:0] w_fwd, w_lat, w_cdeg, w_rng;
    logic               r_valid;
    logic [71:0]        r_data;

    function automatic logic signed [15:0] sat(input logic signed [48:0] v);
        logic signed [15:0] res;
        if (v > 49'(LEN_LIMIT)) begin
            res = LEN_LIMIT;
        end else if (v < -49'(LEN_LIMIT)) begin
            res = -LEN_LIMIT;
        end else begin
            res = 16'(v);
        end
        return res;
    endfunction

    always_comb begin
        w_rel = 32'((i_stage.zero ? '0 : i_stage.vz)
                    - {{2{i_stage.heading[15]}}, i_stage.heading, 16'h0000});
        w_mag = i_stage.zero ? '0 : i_stage.vx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_stage.valid;
            r_a_tag   <= i_stage.tag;
            r_pf      <= 49'(i_stage.rx) * 49'(GAIN_Q16);
            r_pl      <= 49'(i_stage.ry) * 49'(GAIN_Q16);
            r_pr      <= 49'(w_mag) * 49'(GAIN_Q16);
            r_pb      <= 50'(w_rel) * 50'(CDEG_TURN);
        end
    end

    always_comb begin
        w_f = (r_pf + 49'sd536870912) >>> 30;
        w_l = -((r_pl + 49'sd536870912) >>> 30);
        w_r = (r_pr + 49'sd536870912) >>> 30;
        w_b = (r_pb + 50'sd2147483648) >>> 32;
        w_fwd = sat(w_f);
        w_lat = sat(w_l);
        if (w_r < 0) begin
            w_rng = '0;
        end else begin
            w_rng = sat(w_r);
        end
        if (w_b <= -50'(HALF_TURN_CDEG) || w_b > 50'(HALF_TURN_CDEG)) begin
            w_cdeg = HALF_TURN_CDEG;
        end else begin
            w_cdeg = 16'(w_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_a_valid;
            r_data  <= {1'b0, w_rng[14:0], w_cdeg, w_fwd, w_lat, r_a_tag};
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

// ===== tb/world_to_body_range_bearing_top_tb.sv =====
`default_nettype none
module world_to_body_range_bearing_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES = 16;
    localparam int N_RANDOM = 630;
    localparam logic signed [63:0] QTURN = 64'sd1073741824;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;

    typedef struct packed {
        logic [7:0]         tag;
        logic signed [13:0] tx;
        logic signed [13:0] ty;
        logic signed [13:0] rx;
        logic signed [13:0] ry;
        logic signed [15:0] hd;
    } t_detection;

    typedef struct packed {
        logic [7:0]         tag;
        logic signed [15:0] lat;
        logic signed [15:0] fwd;
        logic signed [15:0] brg;
        logic [14:0]        rng;
    } t_fix;

    typedef struct {
        t_detection d;
        logic       known;
        t_fix       r;
    } t_row;

    t_fix pending_fixes[$];
    int   errors = 0;
    bit   send_done = 1'b0;
    bit   hold_off = 1'b0;
    int   hold_count = 0;

    world_to_body_range_bearing_top #(.CORDIC_STAGES(STAGES)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [63:0] mm_round(logic signed [63:0] v);
        return floor_shift(v * 39797 + (64'sd1 <<< 29), 30);
    endfunction

    function automatic logic signed [63:0] clip(logic signed [63:0] v,
                                                logic signed [63:0] lo,
                                                logic signed [63:0] hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_fix body_fix(t_detection d);
        logic signed [63:0] dx, dy, h, x, y, z, t, xs, ys, ang, rel, cd;
        logic [31:0] rel32;
        t_fix f;
        dx = 64'(d.tx) - 64'(d.rx);
        dy = 64'(d.ty) - 64'(d.ry);
        h = 64'(d.hd) * 65536;
        x = dx <<< 14;
        y = dy <<< 14;
        z = -h;
        if (z > QTURN) begin
            t = x; x = -y; y = t; z = z - QTURN;
        end else if (z < -QTURN) begin
            t = x; x = y; y = -t; z = z + QTURN;
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - 64'(wbrb_pkg::ATAN_TAB[i]);
            end else begin
                x = x + ys; y = y - xs; z = z + 64'(wbrb_pkg::ATAN_TAB[i]);
            end
        end
        f.tag = d.tag;
        f.fwd = 16'(clip(mm_round(x), -23170, 23170));
        f.lat = 16'(clip(-mm_round(y), -23170, 23170));
        x = dx <<< 14;
        y = dy <<< 14;
        z = 0;
        if (dx != 0 || dy != 0) begin
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; z = QTURN;
                end else begin
                    t = x; x = -y; y = t; z = -QTURN;
                end
            end
            for (int i = 0; i < STAGES; i++) begin
                xs = floor_shift(x, i);
                ys = floor_shift(y, i);
                if (y < 0) begin
                    x = x - ys; y = y + xs; z = z - 64'(wbrb_pkg::ATAN_TAB[i]);
                end else begin
                    x = x + ys; y = y - xs; z = z + 64'(wbrb_pkg::ATAN_TAB[i]);
                end
            end
        end else begin
            x = 0;
        end
        f.rng = 15'(clip(mm_round(x), 0, 23170));
        ang = z;
        rel32 = 32'(ang - h);
        rel = 64'($signed(rel32));
        cd = floor_shift(rel * 36000 + (64'sd1 <<< 31), 32);
        if (cd <= -18000 || cd > 18000) cd = 18000;
        f.brg = 16'(cd);
        return f;
    endfunction

    function automatic t_detection rand_detection();
        t_detection d;
        d.tag = 8'($urandom);
        d.hd = 16'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            d = {d.tag, 14'($urandom), 14'($urandom), 14'($urandom), 14'($urandom), d.hd};
        end else begin
            d.rx = 14'($signed($urandom_range(0, 6000)) - 3000);
            d.ry = 14'($signed($urandom_range(0, 4000)) - 2000);
            d.tx = d.rx + 14'($signed($urandom_range(0, 1000)) - 500);
            d.ty = d.ry + 14'($signed($urandom_range(0, 1000)) - 500);
        end
        return d;
    endfunction

    task automatic send_detection(t_detection d);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 2) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {d.hd, d.ry, d.rx, d.ty, d.tx, d.tag};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_fixes = {pending_fixes, body_fix(d)};
        @(negedge i_clk);
    endtask

    initial begin
        t_row rows[$];
        t_row r;
        t_fix f;
        // Directed rows: coincident points, half-turn, saturation, extremes.
        r.known = 1'b1;
        r.d = '{8'h00, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 16'sd0};
        r.r = '{8'h00, 16'sd0, 16'sd0, 16'sd0, 15'd0};
        rows = {rows, r};
        r.d = '{8'hFF, 14'sd100, 14'sd100, 14'sd100, 14'sd100, -16'sd32768};
        r.r = '{8'hFF, 16'sd0, 16'sd0, 16'sd18000, 15'd0};
        rows = {rows, r};
        r.d = '{8'h5A, 14'sd8191, 14'sd8191, -14'sd8192, -14'sd8192, 16'sd0};
        r.r = '{8'h5A, 16'sd0, 16'sd0, 16'sd0, 15'd23170};
        r.known = 1'b0;
        rows = {rows, r};
        r.d = '{8'hA5, -14'sd8192, -14'sd8192, 14'sd8191, 14'sd8191, 16'sd32767};
        rows = {rows, r};
        r.d = '{8'h01, 14'sd8191, 14'sd0, -14'sd8192, 14'sd0, 16'sd0};
        rows = {rows, r};
        r.d = '{8'h02, -14'sd8192, 14'sd0, 14'sd8191, 14'sd0, 16'sd0};
        rows = {rows, r};
        r.d = '{8'h03, 14'sd0, 14'sd8191, 14'sd0, -14'sd8192, 16'sd16384};
        rows = {rows, r};
        r.d = '{8'h04, -14'sd1000, 14'sd0, 14'sd0, 14'sd0, 16'sd0};
        rows = {rows, r};
        r.d = '{8'h05, -14'sd1000, 14'sd1, 14'sd0, 14'sd0, -16'sd16384};
        rows = {rows, r};
        r.d = '{8'h06, 14'sd0, -14'sd1000, 14'sd0, 14'sd0, 16'sd32767};
        rows = {rows, r};
        r.d = '{8'h07, 14'sd1, 14'sd1, 14'sd0, 14'sd0, -16'sd1};
        rows = {rows, r};
        r.d = '{8'h08, 14'sd500, -14'sd500, 14'sd0, 14'sd0, 16'sd8192};
        rows = {rows, r};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[i]) begin
            if (rows[i].known) begin
                f = body_fix(rows[i].d);
                if (f != rows[i].r) begin
                    $display("%0t: table row %0d expected %h, predictor %h",
                             $realtime, i, rows[i].r, f);
                    errors++;
                end
            end
            send_detection(rows[i].d);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 200) hold_off = 1'b1;
            send_detection(rand_detection());
        end
        s_axis_tvalid <= 1'b0;
        send_done = 1'b1;
    end

    always @(negedge i_clk) begin
        if (hold_off && hold_count < 200) begin
            hold_count <= hold_count + 1;
            m_axis_tready <= 1'b0;
        end else begin
            hold_off <= 1'b0;
            m_axis_tready <= ($urandom_range(0, 11) < 8) || ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        t_fix got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tdata[39:24],
                    m_axis_tdata[55:40], m_axis_tdata[70:56]};
            if (pending_fixes.size() == 0) begin
                $display("%0t: unexpected beat %h", $realtime, got);
                errors++;
            end else begin
                want = pending_fixes.pop_front();
                if (got.tag != want.tag) begin
                    $display("%0t: tag expected %0d actual %0d", $realtime, want.tag, got.tag);
                    errors++;
                end
                if (got.lat != want.lat) begin
                    $display("%0t: lateral expected %0d actual %0d", $realtime,
                             want.lat, got.lat);
                    errors++;
                end
                if (got.fwd != want.fwd) begin
                    $display("%0t: forward expected %0d actual %0d", $realtime,
                             want.fwd, got.fwd);
                    errors++;
                end
                if (got.brg != want.brg) begin
                    $display("%0t: bearing expected %0d actual %0d", $realtime,
                             want.brg, got.brg);
                    errors++;
                end
                if (got.rng != want.rng) begin
                    $display("%0t: range expected %0d actual %0d", $realtime,
                             want.rng, got.rng);
                    errors++;
                end
            end
        end
    end

    initial begin
        int waited;
        waited = 0;
        wait (send_done);
        while (pending_fixes.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (STAGES + 20) @(posedge i_clk);
        if (errors == 0 && pending_fixes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
